[rtl/core/isc_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// isc_pkg
// Shared types, codes and constants of the intensity displacement scatter core.
// ----------------------------------------------------------------------------
package isc_pkg;

  localparam int MAX_WIDTH_DEF  = 64;
  localparam int MAX_HEIGHT_DEF = 64;

  // wide enough for any frame dimension up to 2048
  localparam int DIM_W   = 12;
  // position plus shift
  localparam int SUM_W   = 17;
  localparam int PIX_W   = 24;
  localparam int SHIFT_W = 16;

  // floor(s / 3) == (s * 683) >> 11 for s <= 765
  localparam int RECIP3    = 683;
  localparam int RECIP3_SH = 11;

  localparam logic [1:0] CMD_START = 2'd0;
  localparam logic [1:0] CMD_PIXEL = 2'd1;
  localparam logic [1:0] CMD_READ  = 2'd2;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_DROPPED = 2'd1;
  localparam logic [1:0] ST_OUTSIDE = 2'd2;

  localparam logic [1:0] REG_FACTOR = 2'd0;
  localparam logic [1:0] REG_WIDTH  = 2'd1;
  localparam logic [1:0] REG_HEIGHT = 2'd2;

  localparam logic [7:0] FACTOR_RST = 8'd1;
  localparam logic [6:0] WIDTH_RST  = 7'd64;
  localparam logic [6:0] HEIGHT_RST = 7'd64;

  typedef struct packed {
    logic [1:0] command;
    logic [7:0] a_red;
    logic [7:0] a_green;
    logic [7:0] a_blue;
    logic [7:0] b_red;
    logic [7:0] b_green;
    logic [7:0] b_blue;
    logic [5:0] read_column;
    logic [5:0] read_row;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_red;
    logic [7:0] out_green;
    logic [7:0] out_blue;
    logic       frame_done;
    logic [1:0] status;
  } out_item_t;

endpackage

[rtl/core/isc_shift.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// isc_shift
// Two-stage shift unit: mean of the B color (divide by three through a
// reciprocal), then scaled by the displacement factor.
// ----------------------------------------------------------------------------
module isc_shift (
  input  logic                        clk,
  input  logic                        ld_quot,
  input  logic                        ld_prod,
  input  logic [7:0]                  b_red,
  input  logic [7:0]                  b_green,
  input  logic [7:0]                  b_blue,
  input  logic [7:0]                  factor,
  output logic [isc_pkg::SHIFT_W-1:0] shift
);
  import isc_pkg::*;

  logic [9:0]         sum;
  logic [19:0]        recip_prod;
  logic [7:0]         quot_r;
  logic [SHIFT_W-1:0] shift_r;

  assign sum        = 10'(b_red) + 10'(b_green) + 10'(b_blue);
  assign recip_prod = 20'(sum) * 20'(RECIP3);

  always_ff @(posedge clk) begin
    if (ld_quot) begin
      quot_r <= recip_prod[RECIP3_SH +: 8];
    end
    if (ld_prod) begin
      shift_r <= SHIFT_W'(quot_r) * SHIFT_W'(factor);
    end
  end

  assign shift = shift_r;

endmodule

[rtl/core/isc_src_store.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// isc_src_store
// Source pixel memory: one write port, one registered read port.
// ----------------------------------------------------------------------------
module isc_src_store #(
  parameter int DEPTH = 4096,
  parameter int AW    = 12
) (
  input  logic                      clk,
  input  logic                      we,
  input  logic [AW-1:0]             waddr,
  input  logic [isc_pkg::PIX_W-1:0] wdata,
  input  logic                      re,
  input  logic [AW-1:0]             raddr,
  output logic [isc_pkg::PIX_W-1:0] rdata
);
  import isc_pkg::*;

  logic [PIX_W-1:0] mem [DEPTH];
  logic [PIX_W-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

[rtl/core/isc_out_store.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// isc_out_store
// Output pixel memory with a clearing sweep, one entry per cycle, run after
// reset and on request.
// ----------------------------------------------------------------------------
module isc_out_store #(
  parameter int DEPTH = 4096,
  parameter int AW    = 12
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      clear_req,
  output logic                      clear_busy,
  input  logic                      we,
  input  logic [AW-1:0]             waddr,
  input  logic [isc_pkg::PIX_W-1:0] wdata,
  input  logic                      re,
  input  logic [AW-1:0]             raddr,
  output logic [isc_pkg::PIX_W-1:0] rdata
);
  import isc_pkg::*;

  logic [PIX_W-1:0] mem [DEPTH];
  logic [PIX_W-1:0] rdata_r;
  logic [AW-1:0]    clr_cnt_r, clr_cnt_nxt;
  logic             busy_r, busy_nxt;
  logic             clr_last;

  assign clr_last = (clr_cnt_r == AW'(DEPTH - 1));

  always_comb begin
    clr_cnt_nxt = clr_cnt_r;
    busy_nxt    = busy_r;
    if (clear_req) begin
      clr_cnt_nxt = '0;
      busy_nxt    = 1'b1;
    end else if (busy_r) begin
      clr_cnt_nxt = clr_cnt_r + 1'b1;
      busy_nxt    = !clr_last;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_cnt_r <= '0;
      busy_r    <= 1'b1;
    end else begin
      clr_cnt_r <= clr_cnt_nxt;
      busy_r    <= busy_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (busy_r) begin
      mem[clr_cnt_r] <= '0;
    end else if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata      = rdata_r;
  assign clear_busy = busy_r;

endmodule

[rtl/core/intensity_displacement_scatter_core.sv]
`timescale 1ns / 1ps
// Pixel pair: result registered on accept; next item taken after S_MUL (shift
//   multiply), S_WRITE (scatter write) and S_FIX on a row move (back-fill); none if dropped.
// Read: result loaded in S_RDATA from the registered store read; outside reads and unused
//   commands load it directly. Start: result registered on accept; the next item waits in
//   S_CLEAR while the output store clear sweep runs over all MAX_WIDTH*MAX_HEIGHT entries.
// Reset: the same clear sweep runs; config writes are taken at any time.
// ----------------------------------------------------------------------------
// intensity_displacement_scatter_core
// Scatters source pixels by the scaled intensity of a displacement image.
// ----------------------------------------------------------------------------
module intensity_displacement_scatter_core #(
  parameter int MAX_WIDTH  = isc_pkg::MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT = isc_pkg::MAX_HEIGHT_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  isc_pkg::in_item_t  in_item,
  output logic               out_valid,
  input  logic               out_stall,
  output isc_pkg::out_item_t out_item,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [1:0]         cfg_index,
  input  logic [7:0]         cfg_data
);
  import isc_pkg::*;

  localparam int CW    = $clog2(MAX_WIDTH);
  localparam int RW    = $clog2(MAX_HEIGHT);
  localparam int RPW   = $clog2(MAX_HEIGHT + 1);
  localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
  localparam int AW    = $clog2(DEPTH);
  localparam logic [DIM_W-1:0] MAXW_E = DIM_W'(MAX_WIDTH);
  localparam logic [DIM_W-1:0] MAXH_E = DIM_W'(MAX_HEIGHT);

  typedef enum logic [5:0] {
    S_CLEAR = 6'b000001,
    S_IDLE  = 6'b000010,
    S_MUL   = 6'b000100,
    S_WRITE = 6'b001000,
    S_FIX   = 6'b010000,
    S_RDATA = 6'b100000
  } state_t;

  function automatic logic [AW-1:0] cell_addr(input logic [DIM_W-1:0] col,
                                               input logic [DIM_W-1:0] row);
    return AW'(row) * AW'(MAX_WIDTH) + AW'(col);
  endfunction

  state_t           state_r, state_nxt;
  logic [7:0]       factor_r;
  logic [6:0]       fwidth_r, fheight_r;
  logic [CW-1:0]    column_pos_r, column_pos_nxt;
  logic [RPW-1:0]   row_pos_r, row_pos_nxt;
  logic [CW-1:0]    x_r;
  logic [RW-1:0]    y_r;
  logic [PIX_W-1:0] a_r;
  logic             out_valid_r, out_valid_nxt;
  out_item_t        out_item_r, out_item_nxt;
  logic             load_out;

  logic [DIM_W-1:0] fw_ext, fh_ext, w_ext, h_ext;
  logic [DIM_W-1:0] cp_ext, rp_ext, cp1, rp1, cp2, col_after, row_after;
  logic [DIM_W-1:0] rc_ext, rr_ext;
  logic             drop, wrap2, done, rd_inside;
  logic             accept, pix_go, clear_req, clear_busy;

  logic [SHIFT_W-1:0] shift;
  logic [DIM_W-1:0]   xe, ye, w_m1, h_m1, dx, dy, py;
  logic [SUM_W-1:0]   dx_sum, dy_sum;
  logic               fix_need;

  logic             src_we, src_re;
  logic [AW-1:0]    src_waddr, src_raddr;
  logic [PIX_W-1:0] src_rdata;
  logic             out_we, out_re;
  logic [AW-1:0]    out_waddr, out_raddr;
  logic [PIX_W-1:0] out_wdata, out_rdata;

  // ---------------- configuration ----------------
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      factor_r  <= FACTOR_RST;
      fwidth_r  <= WIDTH_RST;
      fheight_r <= HEIGHT_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_FACTOR: factor_r  <= cfg_data;
        REG_WIDTH:  fwidth_r  <= cfg_data[6:0];
        REG_HEIGHT: fheight_r <= cfg_data[6:0];
        default:    ;
      endcase
    end
  end

  // frame size clamped to 1..MAX
  assign fw_ext = DIM_W'(fwidth_r);
  assign fh_ext = DIM_W'(fheight_r);
  assign w_ext  = (fw_ext == '0) ? DIM_W'(1) : ((fw_ext > MAXW_E) ? MAXW_E : fw_ext);
  assign h_ext  = (fh_ext == '0) ? DIM_W'(1) : ((fh_ext > MAXH_E) ? MAXH_E : fh_ext);

  // ---------------- raster position ----------------
  assign cp_ext = DIM_W'(column_pos_r);
  assign rp_ext = DIM_W'(row_pos_r);

  always_comb begin
    cp1 = cp_ext;
    rp1 = rp_ext;
    // column beyond a shrunk width wraps first
    if (cp_ext >= w_ext) begin
      cp1 = '0;
      if (rp_ext < h_ext) begin
        rp1 = rp_ext + 1'b1;
      end
    end
    drop  = (rp1 >= h_ext);
    cp2   = cp1 + 1'b1;
    wrap2 = (cp2 >= w_ext);
    if (drop) begin
      col_after = cp1;
      row_after = rp1;
    end else if (wrap2) begin
      col_after = '0;
      row_after = rp1 + 1'b1;
    end else begin
      col_after = cp2;
      row_after = rp1;
    end
    done = !drop && wrap2 && ((rp1 + 1'b1) >= h_ext);
  end

  assign rc_ext    = DIM_W'(in_item.read_column);
  assign rr_ext    = DIM_W'(in_item.read_row);
  assign rd_inside = (rc_ext < w_ext) && (rr_ext < h_ext);

  // ---------------- scatter targets ----------------
  assign xe     = DIM_W'(x_r);
  assign ye     = DIM_W'(y_r);
  assign w_m1   = w_ext - 1'b1;
  assign h_m1   = h_ext - 1'b1;
  assign dx_sum = SUM_W'(xe) + SUM_W'(shift);
  assign dy_sum = SUM_W'(ye) + SUM_W'(shift);
  assign dx     = (dx_sum > SUM_W'(w_m1)) ? w_m1 : DIM_W'(dx_sum);
  assign dy     = (dy_sum > SUM_W'(h_m1)) ? h_m1 : DIM_W'(dy_sum);
  assign py     = (SUM_W'(shift) >= SUM_W'(ye)) ? '0 : (ye - DIM_W'(shift));
  assign fix_need = (dy != ye);

  // ---------------- control ----------------
  assign in_stall = !((state_r == S_IDLE) && (!out_valid_r || !out_stall));
  assign accept   = in_valid && !in_stall;
  assign pix_go   = accept && (in_item.command == CMD_PIXEL) && !drop;

  always_comb begin
    state_nxt      = state_r;
    column_pos_nxt = column_pos_r;
    row_pos_nxt    = row_pos_r;
    clear_req      = 1'b0;
    load_out       = 1'b0;
    out_item_nxt   = '0;
    unique case (state_r)
      S_CLEAR: begin
        if (!clear_busy) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (accept) begin
          unique case (in_item.command)
            CMD_START: begin
              clear_req      = 1'b1;
              column_pos_nxt = '0;
              row_pos_nxt    = '0;
              load_out       = 1'b1;
              state_nxt      = S_CLEAR;
            end
            CMD_PIXEL: begin
              column_pos_nxt          = CW'(col_after);
              row_pos_nxt             = RPW'(row_after);
              load_out                = 1'b1;
              out_item_nxt.frame_done = done;
              out_item_nxt.status     = drop ? ST_DROPPED : ST_OK;
              if (!drop) begin
                state_nxt = S_MUL;
              end
            end
            CMD_READ: begin
              if (rd_inside) begin
                state_nxt = S_RDATA;
              end else begin
                load_out            = 1'b1;
                out_item_nxt.status = ST_OUTSIDE;
              end
            end
            default: begin
              load_out = 1'b1;
            end
          endcase
        end
      end
      S_MUL:   state_nxt = S_WRITE;
      S_WRITE: state_nxt = fix_need ? S_FIX : S_IDLE;
      S_FIX:   state_nxt = S_IDLE;
      S_RDATA: begin
        load_out               = 1'b1;
        out_item_nxt.out_red   = out_rdata[23:16];
        out_item_nxt.out_green = out_rdata[15:8];
        out_item_nxt.out_blue  = out_rdata[7:0];
        out_item_nxt.status    = ST_OK;
        state_nxt              = S_IDLE;
      end
      default: state_nxt = S_CLEAR;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r && out_stall;
    if (load_out) begin
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_CLEAR;
      column_pos_r <= '0;
      row_pos_r    <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      column_pos_r <= column_pos_nxt;
      row_pos_r    <= row_pos_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (pix_go) begin
      x_r <= CW'(cp1);
      y_r <= RW'(rp1);
      a_r <= {in_item.a_red, in_item.a_green, in_item.a_blue};
    end
    if (load_out) begin
      out_item_r <= out_item_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

  // ---------------- memories ----------------
  assign src_we    = pix_go;
  assign src_waddr = cell_addr(cp1, rp1);
  assign src_re    = (state_r == S_WRITE) && fix_need;
  assign src_raddr = cell_addr(xe, py);

  // scatter write first, then back-fill of the current position
  assign out_we    = (state_r == S_WRITE) || (state_r == S_FIX);
  assign out_waddr = (state_r == S_FIX) ? cell_addr(xe, ye) : cell_addr(dx, dy);
  assign out_wdata = (state_r == S_FIX) ? src_rdata : a_r;
  assign out_re    = accept && (in_item.command == CMD_READ) && rd_inside;
  assign out_raddr = cell_addr(rc_ext, rr_ext);

  isc_shift u_shift (
    .clk     (clk),
    .ld_quot (pix_go),
    .ld_prod (state_r == S_MUL),
    .b_red   (in_item.b_red),
    .b_green (in_item.b_green),
    .b_blue  (in_item.b_blue),
    .factor  (factor_r),
    .shift   (shift)
  );

  isc_src_store #(
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_src_store (
    .clk   (clk),
    .we    (src_we),
    .waddr (src_waddr),
    .wdata ({in_item.a_red, in_item.a_green, in_item.a_blue}),
    .re    (src_re),
    .raddr (src_raddr),
    .rdata (src_rdata)
  );

  isc_out_store #(
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_out_store (
    .clk        (clk),
    .rst_n      (rst_n),
    .clear_req  (clear_req),
    .clear_busy (clear_busy),
    .we         (out_we),
    .waddr      (out_waddr),
    .wdata      (out_wdata),
    .re         (out_re),
    .raddr      (out_raddr),
    .rdata      (out_rdata)
  );

  // ---------------- assertions ----------------
  a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
    load_out |-> !(out_valid_r && out_stall))
    else $error("result loaded over a pending item");

  a_fix_after_write: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_FIX) |-> ($past(state_r) == S_WRITE))
    else $error("back-fill without scatter write");

  a_no_accept_clearing: assert property (@(posedge clk) disable iff (!rst_n)
    clear_busy |-> in_stall)
    else $error("item accepted during clear sweep");

  a_target_in_frame: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_WRITE) |-> ((dx < w_ext) && (dy < h_ext)))
    else $error("scatter target outside frame");

  a_read_result: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_RDATA) |=> out_valid_r)
    else $error("read result not presented");

endmodule

[tb/isc_scatter_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// isc_scatter_checker
// Watches the item, result and register channels of the scatter core, keeps
// its own copy of the source and output images, predicts each result and
// compares it field by field with what the core returns.
// ----------------------------------------------------------------------------
module isc_scatter_checker #(
  parameter int MAX_WIDTH  = isc_pkg::MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT = isc_pkg::MAX_HEIGHT_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  logic               in_stall,
  input  isc_pkg::in_item_t  in_item,
  input  logic               out_valid,
  input  logic               out_stall,
  input  isc_pkg::out_item_t out_item,
  input  logic               cfg_valid,
  input  logic               cfg_ready,
  input  logic [1:0]         cfg_index,
  input  logic [7:0]         cfg_data,
  output int                 fail_count,
  output int                 pending,
  output int                 n_results
);
  import isc_pkg::*;

  localparam int          NPIX     = MAX_WIDTH * MAX_HEIGHT;
  localparam int unsigned LUMA_DIV = 3;

  logic [PIX_W-1:0] src_img [NPIX];
  logic [PIX_W-1:0] dst_img [NPIX];
  int unsigned      col_pos;
  int unsigned      row_pos;
  logic [7:0]       factor_r;
  logic [6:0]       width_r;
  logic [6:0]       height_r;
  out_item_t        predicted_out [$];

  function automatic int unsigned clamp_dim(logic [6:0] v, int unsigned lim);
    if (v == 0) return 1;
    if (v > lim) return lim;
    return v;
  endfunction

  function automatic int unsigned pix_addr(int unsigned c, int unsigned r);
    return (r * MAX_WIDTH + c) % NPIX;
  endfunction

  task automatic apply_command(input in_item_t it, output out_item_t res);
    int unsigned w, h, x, y, dx, dy, py, sum, shift;
    logic [PIX_W-1:0] pix;
    w   = clamp_dim(width_r, MAX_WIDTH);
    h   = clamp_dim(height_r, MAX_HEIGHT);
    res = '0;
    case (it.command)
      CMD_START: begin
        foreach (dst_img[i]) dst_img[i] = '0;
        col_pos = 0;
        row_pos = 0;
      end
      CMD_PIXEL: begin
        // width shrunk under the current column: move on to the next row
        if (col_pos >= w) begin
          col_pos = 0;
          if (row_pos < h) row_pos++;
        end
        if (row_pos >= h) begin
          res.status = ST_DROPPED;
        end else begin
          x     = col_pos;
          y     = row_pos;
          pix   = {it.a_red, it.a_green, it.a_blue};
          sum   = it.b_red + it.b_green + it.b_blue;
          shift = (sum / LUMA_DIV) * factor_r;
          dx    = (x + shift > w - 1) ? w - 1 : x + shift;
          dy    = (y + shift > h - 1) ? h - 1 : y + shift;
          src_img[pix_addr(x, y)]   = pix;
          dst_img[pix_addr(dx, dy)] = pix;
          // row moved: back-fill from the source column above
          if (dy != y) begin
            py = (shift >= y) ? 0 : y - shift;
            dst_img[pix_addr(x, y)] = src_img[pix_addr(x, py)];
          end
          col_pos++;
          if (col_pos >= w) begin
            col_pos = 0;
            row_pos++;
            if (row_pos >= h) res.frame_done = 1'b1;
          end
        end
      end
      CMD_READ: begin
        if (it.read_column >= w || it.read_row >= h) begin
          res.status = ST_OUTSIDE;
        end else begin
          {res.out_red, res.out_green, res.out_blue} =
            dst_img[pix_addr(it.read_column, it.read_row)];
        end
      end
      default: ;
    endcase
  endtask

  task automatic check_field(input string name, input logic [7:0] want,
                             input logic [7:0] got);
    if (got !== want) begin
      fail_count++;
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
    end
  endtask

  always @(posedge clk) begin : monitor
    out_item_t want;
    if (!rst_n) begin
      foreach (src_img[i]) src_img[i] = '0;
      foreach (dst_img[i]) dst_img[i] = '0;
      col_pos  = 0;
      row_pos  = 0;
      factor_r = FACTOR_RST;
      width_r  = WIDTH_RST;
      height_r = HEIGHT_RST;
      predicted_out.delete();
      fail_count = 0;
      n_results  = 0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_FACTOR: factor_r = cfg_data;
          REG_WIDTH:  width_r  = cfg_data[6:0];
          REG_HEIGHT: height_r = cfg_data[6:0];
          default: ;
        endcase
      end
      if (in_valid && !in_stall) begin
        apply_command(in_item, want);
        predicted_out.push_back(want);
      end
      if (out_valid && !out_stall) begin
        n_results++;
        if (predicted_out.size() == 0) begin
          fail_count++;
          $display("%0t: unexpected result, expected none, got %p", $time, out_item);
        end else begin
          want = predicted_out.pop_front();
          check_field("out_red", want.out_red, out_item.out_red);
          check_field("out_green", want.out_green, out_item.out_green);
          check_field("out_blue", want.out_blue, out_item.out_blue);
          check_field("frame_done", 8'(want.frame_done), 8'(out_item.frame_done));
          check_field("status", 8'(want.status), 8'(out_item.status));
        end
      end
    end
    pending <= predicted_out.size();
  end

endmodule

[tb/intensity_displacement_scatter_core_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// intensity_displacement_scatter_core_tb
// Drives frames of pixel pairs, reads, starts and stray commands into the
// scatter core under a series of register settings, with random idle bursts
// on both channels; the checker beside the core does all result checking.
// ----------------------------------------------------------------------------
module intensity_displacement_scatter_core_tb;
  import isc_pkg::*;

  localparam int ITEMS  = 1200;
  localparam int TAIL   = 150;
  localparam int LIMIT  = 3_000_000;
  // clear sweep after a start
  localparam int SETTLE = MAX_WIDTH_DEF * MAX_HEIGHT_DEF + 16;
  localparam int IN_W   = $bits(in_item_t);
  // command code the core answers with an all-zero result
  localparam logic [1:0] CMD_SPARE = 2'd3;

  logic      clk;
  logic      rst_n;
  logic      in_valid;
  logic      in_stall;
  in_item_t  in_item;
  logic      out_valid;
  logic      out_stall;
  out_item_t out_item;
  logic      cfg_valid;
  logic      cfg_ready;
  logic [1:0] cfg_index;
  logic [7:0] cfg_data;

  int fail_count;
  int pending;
  int n_results;

  bit          idle_en;
  int unsigned cur_w;
  int unsigned cur_h;
  int unsigned floor_w;    // narrowest width since the last start
  logic [1:0]  last_cmd;
  int          n_sent;
  int          n_pix;
  int          n_read;
  int          n_start;
  int          n_phase;
  longint      cycles;

  intensity_displacement_scatter_core DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  isc_scatter_checker u_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_item    (in_item),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_item   (out_item),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .fail_count (fail_count),
    .pending    (pending),
    .n_results  (n_results)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  // result side back-pressure
  initial begin
    out_stall = 1'b0;
    @(posedge rst_n);
    forever begin
      @(posedge clk);
      if (idle_en && $urandom_range(0, 9) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 17)) @(posedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  function automatic int unsigned eff_dim(int unsigned v);
    if (v == 0) return 1;
    if (v > MAX_WIDTH_DEF) return MAX_WIDTH_DEF;
    return v;
  endfunction

  function automatic in_item_t rand_item(logic [1:0] cmd);
    in_item_t it;
    it = IN_W'({$urandom, $urandom});
    it.command = cmd;
    if ($urandom_range(0, 1) == 0) begin
      // small intensity keeps the B mean at three or below
      it.b_red   = 8'($urandom_range(0, 3));
      it.b_green = 8'($urandom_range(0, 3));
      it.b_blue  = 8'($urandom_range(0, 3));
    end
    return it;
  endfunction

  function automatic in_item_t pair_item(logic [23:0] a, logic [23:0] b);
    in_item_t it;
    it = '0;
    it.command = CMD_PIXEL;
    {it.a_red, it.a_green, it.a_blue} = a;
    {it.b_red, it.b_green, it.b_blue} = b;
    return it;
  endfunction

  function automatic in_item_t read_item(logic [5:0] c, logic [5:0] r);
    in_item_t it;
    it = '0;
    it.command     = CMD_READ;
    it.read_column = c;
    it.read_row    = r;
    return it;
  endfunction

  task automatic send(input in_item_t it);
    if (idle_en && $urandom_range(0, 7) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 17)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_item  <= it;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    last_cmd = it.command;
    case (it.command)
      CMD_START: begin
        n_start++;
        floor_w = cur_w;
      end
      CMD_PIXEL: n_pix++;
      CMD_READ:  n_read++;
      default: ;
    endcase
    if (it.command != CMD_SPARE) n_sent++;
  endtask

  task automatic drain;
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  task automatic cfg_write(input logic [1:0] idx, input logic [7:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
  endtask

  task automatic reconfigure(input logic [7:0] f, input logic [6:0] w, input logic [6:0] h);
    drain();
    if (last_cmd == CMD_START) repeat (SETTLE) @(posedge clk);
    else repeat (8) @(posedge clk);
    cfg_write(REG_FACTOR, f);
    cfg_write(REG_WIDTH, {1'b0, w});
    cfg_write(REG_HEIGHT, {1'b0, h});
    cfg_valid <= 1'b0;
    cur_w = eff_dim(w);
    cur_h = eff_dim(h);
    n_phase++;
  endtask

  function automatic logic [6:0] pick_dim();
    case ($urandom_range(0, 9))
      0: begin
        case ($urandom_range(0, 2))
          0: return 7'd0;
          1: return 7'd64;
          default: return 7'd127;
        endcase
      end
      1: return 7'($urandom_range(0, 127));
      default: return 7'($urandom_range(1, 8));
    endcase
  endfunction

  function automatic logic [7:0] pick_factor();
    case ($urandom_range(0, 9))
      0: return 8'd0;
      1: return 8'd255;
      2: return 8'($urandom_range(0, 255));
      default: return 8'($urandom_range(1, 3));
    endcase
  endfunction

  task automatic random_phase;
    int unsigned target;
    int unsigned done_pix;
    int unsigned roll;
    in_item_t    it;
    reconfigure(pick_factor(), pick_dim(), pick_dim());
    idle_en = (n_sent < ITEMS - TAIL) && ($urandom_range(0, 3) != 0);
    // continuing a frame is only safe when the width has not grown
    if (cur_w > floor_w || $urandom_range(0, 3) != 0) send(rand_item(CMD_START));
    else floor_w = cur_w;
    target = cur_w * cur_h + $urandom_range(0, 3);
    if (target > 150) target = 150;
    done_pix = 0;
    while (done_pix < target) begin
      roll = $urandom_range(0, 99);
      if (roll < 2) begin
        send(rand_item(CMD_START));
      end else if (roll < 4) begin
        send(rand_item(CMD_SPARE));
      end else if (roll < 30) begin
        it = rand_item(CMD_READ);
        if ($urandom_range(0, 9) < 7) begin
          it.read_column = 6'($urandom_range(0, cur_w - 1));
          it.read_row    = 6'($urandom_range(0, cur_h - 1));
        end
        send(it);
      end else begin
        send(rand_item(CMD_PIXEL));
        done_pix++;
      end
    end
    repeat ($urandom_range(2, 6)) begin
      it = rand_item(CMD_READ);
      it.read_column = 6'($urandom_range(0, cur_w - 1));
      it.read_row    = 6'($urandom_range(0, cur_h - 1));
      send(it);
    end
  endtask

  initial begin
    rst_n     = 1'b0;
    in_valid  = 1'b0;
    in_item   = '0;
    cfg_valid = 1'b0;
    cfg_index = REG_FACTOR;
    cfg_data  = '0;
    cycles    = 0;
    idle_en   = 1'b1;
    cur_w     = eff_dim(WIDTH_RST);
    cur_h     = eff_dim(HEIGHT_RST);
    floor_w   = cur_w;
    last_cmd  = CMD_START;
    n_sent    = 0;
    n_pix     = 0;
    n_read    = 0;
    n_start   = 0;
    n_phase   = 0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // one-row frame (zero height register), huge shifts clamp to the corner
    reconfigure(8'd255, 7'd3, 7'd0);
    send(rand_item(CMD_START));
    send(pair_item(24'hFFFFFF, 24'hFFFFFF));
    send(pair_item(24'h000000, 24'h000000));
    send(pair_item(24'h123456, 24'h030303));
    send(pair_item(24'hABCDEF, 24'h000000));   // frame already full
    send(read_item(6'd0, 6'd0));
    send(read_item(6'd1, 6'd0));
    send(read_item(6'd2, 6'd0));
    send(read_item(6'd3, 6'd0));
    send(read_item(6'd0, 6'd1));
    send(read_item(6'd63, 6'd63));
    send(rand_item(CMD_SPARE));

    // oversized width, row shift with back-fill, then width shrunk mid-frame
    reconfigure(8'd1, 7'd127, 7'd2);
    send(rand_item(CMD_START));
    send(pair_item(24'h0A0B0C, 24'h030303));
    send(pair_item(24'hFF0000, 24'h030303));
    send(pair_item(24'h00FF00, 24'h000000));
    reconfigure(8'd2, 7'd2, 7'd2);
    floor_w = cur_w;
    send(pair_item(24'h0000FF, 24'hFFFFFF));
    send(pair_item(24'h808080, 24'h010101));
    send(read_item(6'd1, 6'd1));

    while (n_sent < ITEMS) random_phase();

    drain();
    repeat (16) @(posedge clk);
    $display("Covered %0d pixel pairs, %0d reads and %0d frame starts over %0d register settings;",
             n_pix, n_read, n_start, n_phase);
    $display("%0d results compared against the predicted images.", n_results);
    if (fail_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
